@@ hdl/dlet_pkg.sv @@
// Shared types, constants and state codes for the delta-list event timer.
package dlet_pkg;

  localparam int EventSlotsDefault = 16;
  localparam int MaxFires = 16;

  localparam logic OP_SCHEDULE = 1'b0;
  localparam logic OP_TICK     = 1'b1;

  localparam logic [1:0] ST_SCHEDULED = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_FIRED     = 2'd2;
  localparam logic [1:0] ST_IDLE_TICK = 2'd3;

  typedef struct packed {
    logic        op;
    logic [15:0] delay_ticks;
    logic [7:0]  gate_id;
    logic        repeat_flag;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] fired_gate;
    logic       last;
  } result_t;

  // Controller states, one-hot.
  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_DECODE   = 10'b0000000010,
    S_RD_CUR   = 10'b0000000100,
    S_CMP      = 10'b0000001000,
    S_LINK     = 10'b0000010000,
    S_TICK_RD  = 10'b0000100000,
    S_TICK_CHK = 10'b0001000000,
    S_FIRE     = 10'b0010000000,
    S_NEXT     = 10'b0100000000,
    S_RESULT   = 10'b1000000000
  } state_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic pool_empty;
    logic list_empty;
    logic cur_nil;
    logic new_before_cur;
    logic head_due;
    logic head_zero;
    logic repeating;
  } dp_status_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load_cmd;
    logic alloc;
    logic start_walk;
    logic read_cur;
    logic step;
    logic link_done;
    logic head_read;
    logic head_dec;
    logic head_clear;
    logic pop_head;
    logic free_slot;
    logic start_rearm;
  } dp_cmd_t;

endpackage

@@ hdl/dlet_ram.sv @@
// Generic RAM with one write port, one read port and registered read.
module dlet_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/dlet_datapath.sv @@
// Datapath: slot memories, link table, list heads and walk registers.
module dlet_datapath #(
  parameter int EventSlots = dlet_pkg::EventSlotsDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dlet_pkg::cmd_t        cmd_in,
  input  dlet_pkg::dp_cmd_t     cmd,
  output dlet_pkg::dp_status_t  stat,
  output logic [7:0]            head_gate
);

  localparam int IdxW = $clog2(EventSlots);
  localparam int PtrW = IdxW + 1;
  localparam logic [PtrW-1:0] Nil = PtrW'(EventSlots);

  logic [PtrW-1:0] link [EventSlots];
  logic [EventSlots-1:0] active_mark;
  logic [PtrW-1:0] active_head, free_head;
  logic [PtrW-1:0] ins, prev, cur;
  logic [15:0] new_delta;
  logic [7:0] new_gate;
  logic new_rep;
  logic [15:0] alloc_period;

  logic        d_we;
  logic [IdxW-1:0] d_waddr, d_raddr;
  logic [15:0] d_wdata, d_rdata;
  logic        p_we;
  logic [15:0] p_rdata;
  logic [7:0]  g_rdata;

  logic [IdxW-1:0] ins_i, cur_i, head_i;
  assign ins_i  = ins[IdxW-1:0];
  assign cur_i  = cur[IdxW-1:0];
  assign head_i = active_head[IdxW-1:0];

  // The delta RAM is read at the walk cursor or at the head.
  assign d_raddr = (cmd.head_read) ? head_i : cur_i;

  always_comb begin
    d_we = 1'b0;
    d_waddr = cur_i;
    d_wdata = d_rdata - new_delta;
    if (cmd.step && stat.new_before_cur) begin
      d_we = 1'b1;
    end else if (cmd.link_done) begin
      d_we = 1'b1;
      d_waddr = ins_i;
      d_wdata = new_delta;
    end else if (cmd.head_dec) begin
      d_we = 1'b1;
      d_waddr = head_i;
      d_wdata = d_rdata - 16'd1;
    end else if (cmd.head_clear) begin
      d_we = 1'b1;
      d_waddr = head_i;
      d_wdata = '0;
    end
  end

  assign p_we = cmd.alloc;

  // The period written at allocation follows the repeat flag.
  assign alloc_period = new_rep ? new_delta : 16'd0;

  dlet_ram #(.Width(16), .Depth(EventSlots)) u_delta (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata));

  dlet_ram #(.Width(16), .Depth(EventSlots)) u_period (
    .clk(clk), .we(p_we), .waddr(ins_i), .wdata(alloc_period),
    .raddr(head_i), .rdata(p_rdata));

  dlet_ram #(.Width(8), .Depth(EventSlots)) u_gate (
    .clk(clk), .we(p_we), .waddr(ins_i), .wdata(new_gate),
    .raddr(head_i), .rdata(g_rdata));

  assign head_gate = g_rdata;

  assign stat.pool_empty     = (free_head == Nil);
  assign stat.list_empty     = (active_head == Nil);
  assign stat.cur_nil        = (cur == Nil) || (active_mark == '0);
  assign stat.new_before_cur = (new_delta < d_rdata);
  assign stat.head_due       = (d_rdata <= 16'd1);
  assign stat.head_zero      = (d_rdata == 16'd0);
  assign stat.repeating      = (p_rdata != 16'd0);

  always_ff @(posedge clk) begin
    if (cmd.load_cmd) begin
      new_delta <= (cmd_in.delay_ticks == 16'd0) ? 16'd1 : cmd_in.delay_ticks;
      new_gate  <= cmd_in.gate_id;
      new_rep   <= cmd_in.repeat_flag;
    end
    if (cmd.start_rearm) begin
      new_delta <= p_rdata;
    end
    if (cmd.step && !stat.new_before_cur) begin
      new_delta <= new_delta - d_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < EventSlots; i++) begin
        link[i] <= (i == 0) ? Nil : PtrW'(i - 1);
      end
      active_head <= Nil;
      free_head   <= PtrW'(EventSlots - 1);
      active_mark <= '0;
      prev <= Nil;
      cur  <= Nil;
      ins  <= Nil;
    end else begin
      if (cmd.load_cmd) begin
        ins <= free_head;
      end
      if (cmd.start_rearm) begin
        ins <= active_head;
      end
      if (cmd.alloc) begin
        free_head <= link[ins_i];
      end
      if (cmd.start_walk) begin
        prev <= Nil;
        cur  <= cmd.pop_head ? link[head_i] : active_head;
      end
      if (cmd.step && !stat.new_before_cur) begin
        prev <= cur;
        cur  <= active_mark[cur_i] ? link[cur_i] : Nil;
      end
      if (cmd.link_done) begin
        link[ins_i] <= cur;
        active_mark[ins_i] <= 1'b1;
        if (prev == Nil) begin
          active_head <= ins;
        end else begin
          link[prev[IdxW-1:0]] <= ins;
        end
      end
      if (cmd.pop_head) begin
        active_head <= link[head_i];
        active_mark[head_i] <= 1'b0;
      end
      if (cmd.free_slot) begin
        link[ins_i] <= free_head;
        free_head   <= ins;
      end
    end
  end

endmodule

@@ hdl/dlet_ctrl.sv @@
// Controller state machine sequencing schedule and tick transfers.
module dlet_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  dlet_pkg::cmd_t       cmd_in,
  input  dlet_pkg::dp_status_t stat,
  input  logic [7:0]           head_gate,
  output dlet_pkg::dp_cmd_t    cmd,
  output logic                 busy,
  output logic                 strobe,
  output dlet_pkg::result_t    result
);

  dlet_pkg::state_t state, state_next;
  logic is_tick, firing, rearm;
  logic [4:0] fires;
  logic [7:0] pend_gate;

  assign busy = (state != dlet_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      dlet_pkg::S_IDLE: begin
        if (start) begin
          cmd.load_cmd = 1'b1;
          state_next = dlet_pkg::S_DECODE;
        end
      end
      dlet_pkg::S_DECODE: begin
        if (!is_tick) begin
          if (stat.pool_empty) begin
            state_next = dlet_pkg::S_RESULT;
          end else begin
            cmd.alloc = 1'b1;
            cmd.start_walk = 1'b1;
            state_next = dlet_pkg::S_RD_CUR;
          end
        end else if (stat.list_empty) begin
          state_next = dlet_pkg::S_RESULT;
        end else begin
          cmd.head_read = 1'b1;
          state_next = dlet_pkg::S_TICK_RD;
        end
      end
      dlet_pkg::S_RD_CUR: begin
        cmd.read_cur = 1'b1;
        state_next = dlet_pkg::S_CMP;
      end
      dlet_pkg::S_CMP: begin
        if (stat.cur_nil) begin
          state_next = dlet_pkg::S_LINK;
        end else begin
          cmd.step = 1'b1;
          state_next = stat.new_before_cur ? dlet_pkg::S_LINK : dlet_pkg::S_RD_CUR;
        end
      end
      dlet_pkg::S_LINK: begin
        cmd.link_done = 1'b1;
        state_next = rearm ? dlet_pkg::S_NEXT : dlet_pkg::S_RESULT;
      end
      dlet_pkg::S_TICK_RD: begin
        cmd.head_read = 1'b1;
        state_next = dlet_pkg::S_TICK_CHK;
      end
      dlet_pkg::S_TICK_CHK: begin
        cmd.head_read = 1'b1;
        if (firing) begin
          if (stat.head_zero) begin
            state_next = dlet_pkg::S_FIRE;
          end else begin
            state_next = dlet_pkg::S_RESULT;
          end
        end else if (stat.head_due) begin
          cmd.head_clear = 1'b1;
          state_next = dlet_pkg::S_NEXT;
        end else begin
          cmd.head_dec = 1'b1;
          state_next = dlet_pkg::S_RESULT;
        end
      end
      dlet_pkg::S_FIRE: begin
        cmd.head_read = 1'b1;
        cmd.start_rearm = 1'b1;
        cmd.pop_head = 1'b1;
        state_next = stat.repeating ? dlet_pkg::S_RD_CUR : dlet_pkg::S_NEXT;
        if (stat.repeating) begin
          cmd.start_walk = 1'b1;
        end
      end
      dlet_pkg::S_NEXT: begin
        cmd.free_slot = firing && !rearm && (fires != 5'd0);
        cmd.head_read = 1'b1;
        if (fires == 5'(dlet_pkg::MaxFires) || stat.list_empty) begin
          state_next = dlet_pkg::S_RESULT;
        end else begin
          state_next = dlet_pkg::S_TICK_RD;
        end
      end
      dlet_pkg::S_RESULT: begin
        state_next = dlet_pkg::S_IDLE;
      end
      default: state_next = dlet_pkg::S_IDLE;
    endcase
  end

  // A fired gate is held back until it is known whether another firing follows.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= dlet_pkg::S_IDLE;
      is_tick <= 1'b0;
      firing <= 1'b0;
      rearm  <= 1'b0;
      fires  <= '0;
      pend_gate <= '0;
      strobe <= 1'b0;
      result <= '0;
    end else begin
      state  <= state_next;
      strobe <= 1'b0;
      if (cmd.load_cmd) begin
        is_tick <= (cmd_in.op == dlet_pkg::OP_TICK);
        firing <= 1'b0;
        rearm  <= 1'b0;
        fires  <= '0;
      end
      if (cmd.head_clear) begin
        firing <= 1'b1;
      end
      if (cmd.pop_head) begin
        rearm     <= stat.repeating;
        fires     <= fires + 5'd1;
        pend_gate <= head_gate;
        if (fires != 5'd0) begin
          strobe <= 1'b1;
          result <= '{dlet_pkg::ST_FIRED, pend_gate, 1'b0};
        end
      end
      if (state == dlet_pkg::S_NEXT) begin
        rearm <= 1'b0;
      end
      if (firing && state_next == dlet_pkg::S_RESULT) begin
        result <= '{dlet_pkg::ST_FIRED, pend_gate, 1'b1};
      end
      if (state == dlet_pkg::S_DECODE && !is_tick && stat.pool_empty) begin
        result <= '{dlet_pkg::ST_FULL, 8'd0, 1'b1};
      end
      if (state == dlet_pkg::S_DECODE && is_tick && stat.list_empty) begin
        result <= '{dlet_pkg::ST_IDLE_TICK, 8'd0, 1'b1};
      end
      if (state == dlet_pkg::S_LINK && !rearm) begin
        result <= '{dlet_pkg::ST_SCHEDULED, 8'd0, 1'b1};
      end
      if (cmd.head_dec) begin
        result <= '{dlet_pkg::ST_IDLE_TICK, 8'd0, 1'b1};
      end
      if (state == dlet_pkg::S_RESULT) begin
        strobe <= 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_busy_idle: assert property (@(posedge clk) disable iff (rst)
    (state == dlet_pkg::S_IDLE) |-> !busy) else $error("busy while idle");
  a_fire_cap: assert property (@(posedge clk) disable iff (rst)
    fires <= 5'(dlet_pkg::MaxFires)) else $error("too many firings");
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == dlet_pkg::S_DECODE)) else $error("transfer lost");
`endif

endmodule

@@ hdl/delta_list_event_timer.sv @@
// Top level of the delta-list event timer.
//   channel  | handshake                 | payload
//   command  | start in, busy out        | cmd (dlet_pkg::cmd_t)
//   result   | strobe out, one cycle     | result (dlet_pkg::result_t)
// A schedule keeps busy high while it walks the list slot by slot; a full pool
// ends it without a walk. A tick with nothing due at most decrements the head
// delta; a firing tick pops each due event, and each reinsertion of a repeating
// event walks the list again, paced by the delta RAM with its registered read.
// Reset is synchronous and rebuilds the free chain at once.
// The receiver cannot stall; busy falls as the last result is strobed.
module delta_list_event_timer #(
  parameter int EventSlots = dlet_pkg::EventSlotsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  dlet_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              strobe,
  output dlet_pkg::result_t result
);

  dlet_pkg::dp_cmd_t    dcmd;
  dlet_pkg::dp_status_t stat;
  logic [7:0] head_gate;

  dlet_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .cmd_in(cmd), .stat(stat),
    .head_gate(head_gate), .cmd(dcmd), .busy(busy), .strobe(strobe),
    .result(result));

  dlet_datapath #(.EventSlots(EventSlots)) u_dp (
    .clk(clk), .rst(rst), .cmd_in(cmd), .cmd(dcmd), .stat(stat),
    .head_gate(head_gate));

endmodule
